FILE: rtl/core/chbd_pkg.sv
package chbd_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_W  = 32;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_BIT    = 1'b1;

  typedef enum logic [1:0] {
    PH_COUNTS,
    PH_SYMBOLS,
    PH_DECODE
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_OVERFULL,
    ERR_TOO_LONG,
    ERR_PHASE
  } err_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic table_ready;
    err_t err;
  } res_t;

endpackage

FILE: rtl/core/chbd_ram.sv
module chbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/canonical_huffman_bit_decoder.sv
// Channel  Handshake             Payload
// in       in_valid / in_ready   in_operation, in_header_byte, in_code_bit
// out      out_valid / out_ready out_symbol, out_symbol_valid, out_last,
//                                out_table_ready, out_error_code
// cfg      cfg_valid / cfg_ready cfg_symbols_to_decode (always ready)
//
// One request per cycle unless out stalls; results register in s1_r, then out_r.
// The count RAM is read at the next walk length every cycle, the symbol RAM once per
// completed code; its registered read sets the two-stage result path.
// Reset is synchronous and clears only control state; both RAMs start unwritten.
// A stalled out channel fills the two result stages, then in_ready drops.
module canonical_huffman_bit_decoder #(
  parameter int MAX_CODE_LEN  = 32,
  parameter int ALPHABET_SIZE = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic [chbd_pkg::BYTE_W-1:0] in_header_byte,
  input  logic                       in_code_bit,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [chbd_pkg::BYTE_W-1:0] out_symbol,
  output logic                       out_symbol_valid,
  output logic                       out_last,
  output logic                       out_table_ready,
  output logic [1:0]                 out_error_code,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [chbd_pkg::CFG_W-1:0] cfg_symbols_to_decode
);

  import chbd_pkg::*;

  localparam int PW = MAX_CODE_LEN;
  localparam int LW = $clog2(MAX_CODE_LEN);
  localparam int ML = $clog2(MAX_CODE_LEN + 1);
  localparam int IW = $clog2(ALPHABET_SIZE);
  localparam int CW = $clog2(ALPHABET_SIZE + 1);
  localparam int DW = (PW > 9) ? PW : 9;
  localparam int EW = DW + 2;

  phase_t            phase_r, phase_nxt;
  logic [CW-1:0]     free_r, free_nxt;
  logic [CW-1:0]     expected_r, expected_nxt;
  logic [CW-1:0]     loaded_r, loaded_nxt;
  logic [ML-1:0]     max_len_r, max_len_nxt;
  logic [PW-1:0]     partial_r, partial_nxt;
  logic [PW-1:0]     first_r, first_nxt;
  logic [CW-1:0]     base_r, base_nxt;
  logic [LW-1:0]     cur_len_r, cur_len_nxt;
  logic [CFG_W-1:0]  dec_cnt_r, dec_cnt_nxt;
  logic [CFG_W-1:0]  sym_total_r;

  res_t              res_nxt, s1_r;
  logic              s1_v_r, out_v_r;
  logic              s1_move, in_fire;
  logic [BYTE_W-1:0] out_sym_r;
  res_t              out_r;

  logic              cnt_we;
  logic [LW-1:0]     cnt_waddr, cnt_raddr;
  logic [BYTE_W-1:0] cnt_rdata;
  logic              sym_we, sym_re;
  logic [IW-1:0]     sym_waddr, sym_raddr;
  logic [BYTE_W-1:0] sym_rdata;

  logic [PW-1:0]     partial_bit, code_off;
  logic [ML-1:0]     len_inc, len_c;
  logic              code_ge, hit;
  logic [DW-1:0]     off_d, cnt_d, idx_sum, base_sum;
  logic [DW:0]       fsum;
  logic [CFG_W-1:0]  dec_inc;
  logic [EW-1:0]     byte_e, free_e, nf_e, need_e;
  logic              over, too_long;
  logic [CW-1:0]     loaded_inc;

  assign in_fire  = in_valid && in_ready;
  assign s1_move  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || !out_v_r || out_ready;
  assign cfg_ready = 1'b1;

  assign partial_bit = {partial_r[PW-2:0], in_code_bit};
  assign len_inc     = ML'(cur_len_r) + ML'(1);
  assign code_ge     = partial_bit >= first_r;
  assign code_off    = partial_bit - first_r;
  assign off_d       = DW'(code_off);
  assign cnt_d       = DW'(cnt_rdata);
  assign hit         = code_ge && (off_d < cnt_d);
  assign idx_sum     = DW'(base_r) + off_d;
  assign fsum        = (DW + 1)'(first_r) + (DW + 1)'(cnt_rdata);
  assign base_sum    = DW'(base_r) + cnt_d;
  assign dec_inc     = dec_cnt_r + CFG_W'(1);

  assign byte_e   = EW'(in_header_byte);
  assign free_e   = EW'(free_r);
  assign over     = byte_e > free_e;
  assign nf_e     = (free_e - byte_e) << 1;
  assign len_c    = max_len_r + ML'(1);
  assign need_e   = EW'(expected_r) + byte_e + nf_e;
  assign too_long = (nf_e != '0) &&
                    ((len_c >= ML'(MAX_CODE_LEN)) || (need_e > EW'(ALPHABET_SIZE)));
  assign loaded_inc = loaded_r + CW'(1);

  always_comb begin
    phase_nxt    = phase_r;
    free_nxt     = free_r;
    expected_nxt = expected_r;
    loaded_nxt   = loaded_r;
    max_len_nxt  = max_len_r;
    partial_nxt  = partial_r;
    first_nxt    = first_r;
    base_nxt     = base_r;
    cur_len_nxt  = cur_len_r;
    dec_cnt_nxt  = dec_cnt_r;
    res_nxt      = '{hit: 1'b0, last: 1'b0, table_ready: 1'b0, err: ERR_NONE};
    cnt_we       = 1'b0;
    cnt_waddr    = max_len_r[LW-1:0];
    sym_we       = 1'b0;
    sym_waddr    = loaded_r[IW-1:0];
    sym_re       = 1'b0;
    sym_raddr    = idx_sum[IW-1:0];
    if (in_fire) begin
      unique case (phase_r)
        PH_COUNTS: begin
          if (in_operation != OP_HEADER) begin
            res_nxt.err = ERR_PHASE;
          end else if (over) begin
            res_nxt.err = ERR_OVERFULL;
          end else if (too_long) begin
            res_nxt.err = ERR_TOO_LONG;
          end else begin
            cnt_we       = 1'b1;
            expected_nxt = expected_r + CW'(in_header_byte);
            free_nxt     = nf_e[CW-1:0];
            max_len_nxt  = len_c;
            if (nf_e == '0) begin
              phase_nxt = PH_SYMBOLS;
            end
          end
        end
        PH_SYMBOLS: begin
          if (in_operation != OP_HEADER) begin
            res_nxt.err = ERR_PHASE;
          end else begin
            sym_we     = 1'b1;
            loaded_nxt = loaded_inc;
            if (loaded_inc >= expected_r) begin
              phase_nxt = PH_DECODE;
            end
          end
        end
        PH_DECODE: begin
          if (in_operation != OP_BIT) begin
            res_nxt.err = ERR_PHASE;
          end else if (hit) begin
            sym_re      = 1'b1;
            res_nxt.hit = 1'b1;
            partial_nxt = '0;
            first_nxt   = '0;
            base_nxt    = '0;
            cur_len_nxt = '0;
            if (dec_inc == sym_total_r) begin
              res_nxt.last = 1'b1;
              dec_cnt_nxt  = '0;
            end else begin
              dec_cnt_nxt = dec_inc;
            end
          end else if (len_inc >= max_len_r) begin
            res_nxt.err = ERR_TOO_LONG;
            partial_nxt = '0;
            first_nxt   = '0;
            base_nxt    = '0;
            cur_len_nxt = '0;
          end else begin
            partial_nxt = partial_bit;
            first_nxt   = {fsum[PW-2:0], 1'b0};
            base_nxt    = base_sum[CW-1:0];
            cur_len_nxt = len_inc[LW-1:0];
          end
        end
        default: begin
        end
      endcase
      res_nxt.table_ready = (phase_nxt == PH_DECODE);
    end
  end

  assign cnt_raddr = cur_len_nxt;

  chbd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MAX_CODE_LEN)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (cnt_waddr),
    .wr_data (in_header_byte),
    .rd_en   (1'b1),
    .rd_addr (cnt_raddr),
    .rd_data (cnt_rdata)
  );

  chbd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(ALPHABET_SIZE)
  ) u_sym_ram (
    .clk     (clk),
    .wr_en   (sym_we),
    .wr_addr (sym_waddr),
    .wr_data (in_header_byte),
    .rd_en   (sym_re),
    .rd_addr (sym_raddr),
    .rd_data (sym_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_COUNTS;
      free_r      <= CW'(2);
      expected_r  <= '0;
      loaded_r    <= '0;
      max_len_r   <= '0;
      partial_r   <= '0;
      first_r     <= '0;
      base_r      <= '0;
      cur_len_r   <= '0;
      dec_cnt_r   <= '0;
      sym_total_r <= '0;
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      free_r     <= free_nxt;
      expected_r <= expected_nxt;
      loaded_r   <= loaded_nxt;
      max_len_r  <= max_len_nxt;
      partial_r  <= partial_nxt;
      first_r    <= first_nxt;
      base_r     <= base_nxt;
      cur_len_r  <= cur_len_nxt;
      dec_cnt_r  <= dec_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        sym_total_r <= cfg_symbols_to_decode;
      end
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= res_nxt;
    end
    if (s1_move) begin
      out_r     <= s1_r;
      out_sym_r <= s1_r.hit ? sym_rdata : '0;
    end
  end

  assign out_valid        = out_v_r;
  assign out_symbol       = out_sym_r;
  assign out_symbol_valid = out_r.hit;
  assign out_last         = out_r.last;
  assign out_table_ready  = out_r.table_ready;
  assign out_error_code   = out_r.err;

  a_sym_needs_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_symbol_valid |-> out_table_ready)
    else $error("symbol emitted before table complete");

  a_sym_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_symbol_valid || out_last) |->
      out_symbol_valid && out_error_code == ERR_NONE)
    else $error("last without symbol or symbol with error");

  a_decode_full: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DECODE |-> free_r == '0 && max_len_r != '0)
    else $error("decode entered with incomplete code");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DECODE |-> ML'(cur_len_r) < max_len_r)
    else $error("walk length beyond longest code");

endmodule
